// File: rtl/tts_pkg.sv
// Shared types, codes and defaults for the timeout table scheduler.
package tts_pkg;

    // Default sizes
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Field widths
    localparam int OP_W     = 2;
    localparam int ID_FLD_W = 8;
    localparam int DELAY_W  = 16;
    localparam int STATUS_W = 3;
    localparam int TIME_W   = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SCHEDULED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DECIDE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch a new transaction
        logic scan;     // read slot at scan address, advance
        logic restart;  // clear scan results, begin another pass
        logic commit;   // act on scan results
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_last;
        logic            best_found;
    } t_dp_stat;

endpackage

// File: rtl/timeout_table_scheduler.sv
// Top level of the timeout table scheduler: controller plus datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  command  | start, busy              | i_op, i_timer_id, i_delay_seconds
//  result   | o_valid (one-cycle pulse)| o_status, o_result_id, o_last_of_run
//
// A transaction is taken when start is high and busy is low. Each pass over
// the slot table reads one slot a cycle from the table memory port. Schedule
// and cancel take one pass; a tick takes one pass per expired entry plus one.
// Reset synchronously clears the slot valid bits and time. The receiver
// cannot stall results.
module timeout_table_scheduler #(
    parameter int TIMER_SLOTS = tts_pkg::TIMER_SLOTS_DEF,
    parameter int ID_BITS     = tts_pkg::ID_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tts_pkg::OP_W-1:0]       i_op,
    input  logic [tts_pkg::ID_FLD_W-1:0]   i_timer_id,
    input  logic [tts_pkg::DELAY_W-1:0]    i_delay_seconds,
    output logic                           o_valid,
    output logic [tts_pkg::STATUS_W-1:0]   o_status,
    output logic [tts_pkg::ID_FLD_W-1:0]   o_result_id,
    output logic                           o_last_of_run
);
    import tts_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    // Slot table and result path
    tts_dp #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_op            (i_op),
        .i_timer_id      (i_timer_id),
        .i_delay_seconds (i_delay_seconds),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_result_id     (o_result_id),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// File: rtl/tts_ctrl.sv
// Controller state machine: sequences slot scans and commits.
module tts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [tts_pkg::OP_W-1:0] i_op,
    input  tts_pkg::t_dp_stat     i_stat,
    output tts_pkg::t_dp_cmd      o_cmd,
    output logic                  busy
);
    import tts_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_op != OP_UNUSED) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_last) n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                // another pass while expired entries remain
                if (i_stat.op == OP_TICK && i_stat.best_found) n_state = S_SCAN;
                else n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && start;
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.commit  = (r_state == S_DECIDE);
        o_cmd.restart = (r_state == S_DECIDE) && (i_stat.op == OP_TICK) && i_stat.best_found;
        busy          = (r_state != S_IDLE);
    end

endmodule

// File: rtl/tts_dp.sv
// Datapath: slot table, time counter, scan comparators and result register.
module tts_dp #(
    parameter int TIMER_SLOTS = tts_pkg::TIMER_SLOTS_DEF,
    parameter int ID_BITS     = tts_pkg::ID_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tts_pkg::t_dp_cmd               i_cmd,
    output tts_pkg::t_dp_stat              o_stat,
    input  logic [tts_pkg::OP_W-1:0]       i_op,
    input  logic [tts_pkg::ID_FLD_W-1:0]   i_timer_id,
    input  logic [tts_pkg::DELAY_W-1:0]    i_delay_seconds,
    output logic                           o_valid,
    output logic [tts_pkg::STATUS_W-1:0]   o_status,
    output logic [tts_pkg::ID_FLD_W-1:0]   o_result_id,
    output logic                           o_last_of_run
);
    import tts_pkg::*;

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    // stored id width: ID_BITS, capped at the 8-bit id field
    localparam int ID_W   = (ID_BITS < ID_FLD_W) ? ID_BITS : ID_FLD_W;

    // Slot table
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [ID_W-1:0]        mem_id [TIMER_SLOTS];
    logic [TIME_W-1:0]      mem_dl [TIMER_SLOTS];

    // Transaction and time
    logic [TIME_W-1:0]  r_time;
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_in_id;
    logic [DELAY_W-1:0] r_delay;

    // Scan address and read stage
    logic [SLOT_W-1:0] r_addr;
    logic              r_rd_en;
    logic [SLOT_W-1:0] r_rd_slot;
    logic              r_rd_vld;
    logic [ID_W-1:0]   r_rd_id;
    logic [TIME_W-1:0] r_rd_dl;

    // Scan results
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_free;
    logic [SLOT_W-1:0] r_free_slot;
    logic              r_best;
    logic [SLOT_W-1:0] r_best_slot;
    logic [TIME_W-1:0] r_best_age;
    logic [ID_W-1:0]   r_best_id;

    // Expired entry held back until the next pass says whether it is last
    logic              r_pend;
    logic [ID_W-1:0]   r_pend_id;

    // Result register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_last;

    logic [TIME_W-1:0] rd_age;
    logic              rd_expired;
    logic              rd_better;
    logic              scan_last;

    assign scan_last  = (r_addr == SLOT_W'(TIMER_SLOTS - 1));
    assign rd_age     = r_time - r_rd_dl;
    assign rd_expired = r_rd_vld && !rd_age[TIME_W-1];
    assign rd_better  = !r_best || (rd_age > r_best_age) ||
                        ((rd_age == r_best_age) && (r_rd_id < r_best_id));

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == OP_SCHEDULE && !r_hit && r_free) begin
            mem_id[r_free_slot] <= r_in_id;
            mem_dl[r_free_slot] <= r_time + TIME_W'(r_delay);
        end
        if (i_cmd.scan) begin
            r_rd_id <= mem_id[r_addr];
            r_rd_dl <= mem_dl[r_addr];
        end
    end

    // Transaction latch, time counter, scan address, read stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_addr  <= '0;
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= i_cmd.scan;
            if (i_cmd.load) begin
                r_op    <= i_op;
                r_in_id <= i_timer_id[ID_W-1:0];
                r_delay <= i_delay_seconds;
                r_addr  <= '0;
                if (i_op == OP_TICK) r_time <= r_time + 1'b1;
            end else if (i_cmd.restart) begin
                r_addr <= '0;
            end else if (i_cmd.scan) begin
                r_addr <= scan_last ? '0 : r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_slot <= r_addr;
            r_rd_vld  <= r_valid[r_addr];
        end
    end

    // Scan comparators: id match, first free slot, earliest expired entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_best <= 1'b0;
        end else if (i_cmd.load || i_cmd.restart) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_best <= 1'b0;
        end else if (r_rd_en) begin
            if (r_rd_vld && r_rd_id == r_in_id && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_rd_slot;
            end
            if (!r_rd_vld && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= r_rd_slot;
            end
            if (rd_expired && rd_better) begin
                r_best      <= 1'b1;
                r_best_slot <= r_rd_slot;
                r_best_age  <= rd_age;
                r_best_id   <= r_rd_id;
            end
        end
    end

    // Commit: update slots and emit results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cmd.load) r_pend <= 1'b0;
            if (i_cmd.commit) begin
                case (r_op)
                    OP_TICK: begin
                        if (r_best) begin
                            r_valid[r_best_slot] <= 1'b0;
                            r_pend               <= 1'b1;
                            r_pend_id            <= r_best_id;
                            if (r_pend) begin
                                r_out_vld    <= 1'b1;
                                r_out_status <= ST_EXPIRED;
                                r_out_id     <= r_pend_id;
                                r_out_last   <= 1'b0;
                            end
                        end else begin
                            r_pend <= 1'b0;
                            if (r_pend) begin
                                r_out_vld    <= 1'b1;
                                r_out_status <= ST_EXPIRED;
                                r_out_id     <= r_pend_id;
                                r_out_last   <= 1'b1;
                            end
                        end
                    end
                    OP_SCHEDULE: begin
                        r_out_vld  <= 1'b1;
                        r_out_id   <= r_in_id;
                        r_out_last <= 1'b1;
                        if (r_hit) begin
                            r_out_status <= ST_DUPLICATE;
                        end else if (r_free) begin
                            r_valid[r_free_slot] <= 1'b1;
                            r_out_status         <= ST_SCHEDULED;
                        end else begin
                            r_out_status <= ST_FULL;
                        end
                    end
                    OP_CANCEL: begin
                        r_out_vld  <= 1'b1;
                        r_out_id   <= r_in_id;
                        r_out_last <= 1'b1;
                        if (r_hit) begin
                            r_valid[r_hit_slot] <= 1'b0;
                            r_out_status        <= ST_CANCELLED;
                        end else begin
                            r_out_status <= ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Status to controller and result ports
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.scan_last  = scan_last;
        o_stat.best_found = r_best;
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out_status;
    assign o_result_id   = ID_FLD_W'(r_out_id);
    assign o_last_of_run = r_out_last;

endmodule
